/* hdl/ercu_pkg.sv */
// shared types, register codes and helper functions for the entropy
// estimate and reseed control unit; no dependencies
package ercu_pkg;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [1:0] REG_ACTIVE    = 2'd0;
  localparam logic [1:0] REG_FAST_THR  = 2'd1;
  localparam logic [1:0] REG_SLOW_THR  = 2'd2;
  localparam logic [1:0] REG_SLOW_NEED = 2'd3;

  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_FAST = 2'd1;
  localparam logic [1:0] EV_SLOW = 2'd2;

  localparam logic [4:0]  RST_ACTIVE    = 5'd0;
  localparam logic [11:0] RST_FAST_THR  = 12'd100;
  localparam logic [10:0] RST_SLOW_THR  = 11'd160;
  localparam logic [4:0]  RST_SLOW_NEED = 5'd2;

  localparam logic [5:0]  CREDIT_CAP = 6'd32;
  localparam logic [15:0] SAT_MAX    = 16'hFFFF;

  typedef struct packed {
    logic [4:0]  active_sources;
    logic [11:0] fast_threshold;
    logic [10:0] slow_threshold;
    logic [4:0]  slow_sources_needed;
  } cfg_t;

  typedef struct packed {
    logic take;
    logic delta1;
    logic delta2;
    logic delta3;
    logic score;
    logic pool;
    logic walk_init;
    logic walk;
    logic decide;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic refuse;
    logic to_fast;
    logic slow_check;
    logic walk_done;
  } sts_t;

  function automatic logic [31:0] abs32(input logic [31:0] x);
    return x[31] ? 32'(32'd0 - x) : x;
  endfunction

  // index of the highest set bit, zero for zero
  function automatic logic [3:0] log2_est(input logic [11:0] x);
    logic [3:0] r;
    r = 4'd0;
    for (int i = 1; i < 12; i++) begin
      if (x[i]) r = 4'(i);
    end
    return r;
  endfunction

  function automatic logic [15:0] sat16(input logic [15:0] a, input logic [5:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {11'd0, b};
    return s[16] ? SAT_MAX : s[15:0];
  endfunction

endpackage

/* hdl/entropy_estimate_reseed_control_unit.sv */
// top level of the entropy estimate and reseed control unit
// depends on ercu_pkg, ercu_regs, ercu_ctrl, ercu_dp
//
// Scores one entropy sample at a time with a per-source third-order delta
// estimator, credits it to the fast or slow pool in turn and reports a fast
// or slow reseed. An accepted sample passes the history read, the three
// delta steps, score and pool before its result loads; a refused one goes
// straight to the result load. A slow-pool sample that reaches the slow
// level adds a walk over the source contribution memory, one read per
// cycle through its single read port, before the decide step. A stalled
// result keeps the sequencer waiting until the output register frees.
// The next sample is taken as soon as the sequencer is back in idle, while
// the previous result may still sit in the output register.
module entropy_estimate_reseed_control_unit #(
  parameter int MAX_SOURCES = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [3:0]                  source_number,
  input  logic signed [63:0]          sample_value,
  input  logic [6:0]                  claimed_bits,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        accepted,
  output logic [5:0]                  credited_bits,
  output logic                        to_fast_pool,
  output logic [1:0]                  reseed_event,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ercu_pkg::ADDR_W-1:0] paddr,
  input  logic [ercu_pkg::DATA_W-1:0] pwdata,
  output logic [ercu_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import ercu_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  ercu_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ercu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ercu_dp #(.MAX_SOURCES(MAX_SOURCES)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .cmd           (cmd),
    .sts           (sts),
    .source_number (source_number),
    .sample_value  (sample_value),
    .claimed_bits  (claimed_bits),
    .accepted      (accepted),
    .credited_bits (credited_bits),
    .to_fast_pool  (to_fast_pool),
    .reseed_event  (reseed_event)
  );

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a beat is in flight");

  a_refused_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !accepted |-> credited_bits == 6'd0 && reseed_event == EV_NONE
      && !to_fast_pool)
    else $error("refused beat carries credit or event");

  a_slow_on_slow_pool: assert property (@(posedge clk) disable iff (rst)
    out_valid && reseed_event == EV_SLOW |-> accepted && !to_fast_pool)
    else $error("slow reseed on a fast pool beat");

  a_fast_on_fast_pool: assert property (@(posedge clk) disable iff (rst)
    out_valid && reseed_event == EV_FAST |-> accepted && to_fast_pool)
    else $error("fast reseed on a slow pool beat");

  a_credit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> credited_bits <= 6'd11)
    else $error("credit above estimator range");

endmodule

/* hdl/ercu_ram.sv */
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module ercu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/ercu_regs.sv */
// apb configuration registers of the reseed control unit
// depends on ercu_pkg
module ercu_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ercu_pkg::ADDR_W-1:0]   paddr,
  input  logic [ercu_pkg::DATA_W-1:0]   pwdata,
  output logic [ercu_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output ercu_pkg::cfg_t                cfg
);
  import ercu_pkg::*;

  logic       wr;
  logic [1:0] reg_sel;

  assign pready  = 1'b1;
  assign wr      = psel & penable & pwrite & pready;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_sources      <= RST_ACTIVE;
      cfg.fast_threshold      <= RST_FAST_THR;
      cfg.slow_threshold      <= RST_SLOW_THR;
      cfg.slow_sources_needed <= RST_SLOW_NEED;
    end else if (wr) begin
      case (reg_sel)
        REG_ACTIVE:    cfg.active_sources      <= pwdata[4:0];
        REG_FAST_THR:  cfg.fast_threshold      <= pwdata[11:0];
        REG_SLOW_THR:  cfg.slow_threshold      <= pwdata[10:0];
        REG_SLOW_NEED: cfg.slow_sources_needed <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_ACTIVE:    prdata = {27'd0, cfg.active_sources};
      REG_FAST_THR:  prdata = {20'd0, cfg.fast_threshold};
      REG_SLOW_THR:  prdata = {21'd0, cfg.slow_threshold};
      REG_SLOW_NEED: prdata = {27'd0, cfg.slow_sources_needed};
      default:       prdata = '0;
    endcase
  end

endmodule

/* hdl/ercu_ctrl.sv */
// sequencing state machine of the reseed control unit
// depends on ercu_pkg
module ercu_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  ercu_pkg::sts_t sts,
  output ercu_pkg::cmd_t cmd
);
  import ercu_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_HREAD  = 4'd1;
  localparam logic [3:0] ST_DELTA1 = 4'd2;
  localparam logic [3:0] ST_DELTA2 = 4'd3;
  localparam logic [3:0] ST_DELTA3 = 4'd4;
  localparam logic [3:0] ST_SCORE  = 4'd5;
  localparam logic [3:0] ST_POOL   = 4'd6;
  localparam logic [3:0] ST_WALK   = 4'd7;
  localparam logic [3:0] ST_DECIDE = 4'd8;
  localparam logic [3:0] ST_DONE   = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = sts.refuse ? ST_DONE : ST_HREAD;
        end
      end
      ST_HREAD: state_next = ST_DELTA1;
      ST_DELTA1: begin
        cmd.delta1 = 1'b1;
        state_next = ST_DELTA2;
      end
      ST_DELTA2: begin
        cmd.delta2 = 1'b1;
        state_next = ST_DELTA3;
      end
      ST_DELTA3: begin
        cmd.delta3 = 1'b1;
        state_next = ST_SCORE;
      end
      ST_SCORE: begin
        cmd.score  = 1'b1;
        state_next = ST_POOL;
      end
      ST_POOL: begin
        cmd.pool = 1'b1;
        if (!sts.to_fast && sts.slow_check) begin
          cmd.walk_init = 1'b1;
          state_next    = ST_WALK;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_done) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* hdl/ercu_dp.sv */
// datapath of the reseed control unit: delta estimator, pools, source walk
// depends on ercu_pkg and ercu_ram
module ercu_dp #(
  parameter int MAX_SOURCES = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  ercu_pkg::cfg_t      cfg,
  input  ercu_pkg::cmd_t      cmd,
  output ercu_pkg::sts_t      sts,
  input  logic [3:0]          source_number,
  input  logic signed [63:0]  sample_value,
  input  logic [6:0]          claimed_bits,
  output logic                accepted,
  output logic [5:0]          credited_bits,
  output logic                to_fast_pool,
  output logic [1:0]          reseed_event
);
  import ercu_pkg::*;

  localparam int IW = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
  localparam int KW = (IW + 1 > 5) ? IW + 1 : 5;
  localparam int HW = 96;
  localparam logic [KW-1:0] MAX_K = KW'(MAX_SOURCES);

  logic [KW-1:0] active_ext;
  logic [KW-1:0] n_act;

  logic [3:0]    s_q;
  logic [IW-1:0] s_idx;
  logic [31:0]   v_q;
  logic [6:0]    claim_q;
  logic          refused_q;

  logic [HW-1:0] hist_rd;
  logic [HW-1:0] hist_wd;
  logic [15:0]   contrib_rd;
  logic [IW-1:0] contrib_raddr;
  logic [MAX_SOURCES-1:0] hist_valid;
  logic [MAX_SOURCES-1:0] contrib_valid;
  logic          hv;

  logic [31:0] d1_q, d2_q, pd_q, psd_q, d3;
  logic [31:0] a1_q, a2_q, a3_q, m;
  logic [15:0] contrib_q;
  logic [3:0]  est;
  logic [6:0]  cmin;
  logic [5:0]  credit_q;

  logic [15:0] fast_acc, slow_acc;
  logic [15:0] fast_new, slow_new, contrib_new;
  logic        sel_fast;
  logic        tofast_q;
  logic [1:0]  ev_q;

  logic [KW-1:0] k;
  logic          pend;
  logic [IW-1:0] pidx;
  logic [4:0]    qual;
  logic          qual_ok;

  assign active_ext = KW'(cfg.active_sources);
  assign n_act      = (active_ext > MAX_K) ? MAX_K : active_ext;
  assign s_idx      = IW'(s_q);

  assign sts.refuse     = KW'(source_number) >= n_act;
  assign sts.to_fast    = sel_fast;
  assign sts.slow_check = slow_new >= {4'd0, cfg.slow_threshold, 1'b0};
  assign sts.walk_done  = (k == n_act) && !pend;

  // history layout: low word of last value, last delta, last second delta
  assign hist_wd       = {v_q, d1_q, d2_q};
  assign contrib_raddr = cmd.walk ? k[IW-1:0] : s_idx;

  ercu_ram #(.WIDTH(HW), .DEPTH(MAX_SOURCES)) u_hist_ram (
    .clk   (clk),
    .we    (cmd.delta3),
    .waddr (s_idx),
    .wdata (hist_wd),
    .raddr (s_idx),
    .rdata (hist_rd)
  );

  ercu_ram #(.WIDTH(16), .DEPTH(MAX_SOURCES)) u_contrib_ram (
    .clk   (clk),
    .we    (cmd.pool && !sel_fast),
    .waddr (s_idx),
    .wdata (contrib_new),
    .raddr (contrib_raddr),
    .rdata (contrib_rd)
  );

  assign hv = hist_valid[s_idx];
  assign d3 = d2_q - psd_q;

  always_comb begin
    m = a1_q;
    if ($signed(a2_q) < $signed(m)) m = a2_q;
    if ($signed(a3_q) < $signed(m)) m = a3_q;
  end

  assign est  = log2_est(m[12:1]);
  assign cmin = (claim_q < {3'd0, est}) ? claim_q : {3'd0, est};

  assign fast_new    = sat16(fast_acc, credit_q);
  assign slow_new    = sat16(slow_acc, credit_q);
  assign contrib_new = sat16(contrib_q, credit_q);
  assign qual_ok     = qual >= cfg.slow_sources_needed;

  // sample capture, estimator pipeline and result output registers
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      s_q       <= source_number;
      v_q       <= sample_value[31:0];
      claim_q   <= claimed_bits;
      refused_q <= sts.refuse;
    end
    if (cmd.delta1) begin
      d1_q      <= v_q - (hv ? hist_rd[95:64] : 32'd0);
      pd_q      <= hv ? hist_rd[63:32] : 32'd0;
      psd_q     <= hv ? hist_rd[31:0] : 32'd0;
      contrib_q <= contrib_valid[s_idx] ? contrib_rd : 16'd0;
    end
    if (cmd.delta2) begin
      d2_q <= d1_q - pd_q;
    end
    if (cmd.delta3) begin
      a1_q <= abs32(d1_q);
      a2_q <= abs32(d2_q);
      a3_q <= abs32(d3);
    end
    if (cmd.score) begin
      credit_q <= (cmin > {1'b0, CREDIT_CAP}) ? CREDIT_CAP : cmin[5:0];
    end
    if (cmd.load_out) begin
      accepted      <= !refused_q;
      credited_bits <= refused_q ? 6'd0 : credit_q;
      to_fast_pool  <= refused_q ? 1'b0 : tofast_q;
      reseed_event  <= refused_q ? EV_NONE : ev_q;
    end
  end

  // pools, valid bits and reseed event
  always_ff @(posedge clk) begin
    if (rst) begin
      fast_acc      <= '0;
      slow_acc      <= '0;
      sel_fast      <= 1'b1;
      tofast_q      <= 1'b0;
      ev_q          <= EV_NONE;
      hist_valid    <= '0;
      contrib_valid <= '0;
    end else begin
      if (cmd.take) begin
        ev_q <= EV_NONE;
      end
      if (cmd.delta3) begin
        hist_valid[s_idx] <= 1'b1;
      end
      if (cmd.pool) begin
        tofast_q <= sel_fast;
        sel_fast <= !sel_fast;
        if (sel_fast) begin
          if (fast_new >= {4'd0, cfg.fast_threshold}) begin
            fast_acc <= '0;
            ev_q     <= EV_FAST;
          end else begin
            fast_acc <= fast_new;
          end
        end else begin
          slow_acc             <= slow_new;
          contrib_valid[s_idx] <= 1'b1;
        end
      end
      if (cmd.decide && qual_ok) begin
        slow_acc <= '0;
        fast_acc <= '0;
        ev_q     <= EV_SLOW;
        for (int i = 0; i < MAX_SOURCES; i++) begin
          if (KW'(i) < n_act) contrib_valid[i] <= 1'b0;
        end
      end
    end
  end

  // walk over source contributions, one read per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      k    <= '0;
      pend <= 1'b0;
      pidx <= '0;
      qual <= '0;
    end else if (cmd.walk_init) begin
      k    <= '0;
      pend <= 1'b0;
      qual <= '0;
    end else if (cmd.walk) begin
      if (k < n_act) begin
        k    <= KW'(k + 1'b1);
        pend <= 1'b1;
        pidx <= k[IW-1:0];
      end else begin
        pend <= 1'b0;
      end
      if (pend && contrib_valid[pidx] && (contrib_rd > {5'd0, cfg.slow_threshold})) begin
        qual <= 5'(qual + 1'b1);
      end
    end
  end

endmodule
